@@ design/lpht_pkg.sv @@
// Shared types and constants for the linear probing hash table unit.
package lpht_pkg;

  // Table geometry. The home slot is taken as key mod TABLE_SIZE, a power of two.
  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;
  localparam int REC_W      = 32;
  localparam int SLOT_W     = 6;

  // Operation codes carried on the action field.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_PROBE = 1'b1
  } state_t;

  // One memory entry: stored key and record word.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
  } entry_t;

endpackage

@@ design/linear_probe_hash_table_unit.sv @@
// Top level of the open-addressed hash table with linear probing.
//
//   Channel | Direction | Ports                                    | Flow control
//   in      | input     | in_action, in_key, in_record_data        | in_valid / in_stall
//   out     | output    | out_status, out_slot_index, out_found_data | out_valid / out_stall
//
// An item is accepted in S_IDLE and then probes up to TABLE_SIZE slots in S_PROBE; the
// single read port of the key and record memory sets one probe per cycle.
// Reset clears the occupancy flags in flip-flops at once, so there is no clearing pass.
// A finished result sits in the output register while the next item is accepted.
// A probe that has its answer waits in place while the output register is still full.
module linear_probe_hash_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [lpht_pkg::KEY_W-1:0]    in_key,
  input  logic [lpht_pkg::REC_W-1:0]    in_record_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [lpht_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [lpht_pkg::REC_W-1:0]    out_found_data
);

  localparam int TS    = lpht_pkg::TABLE_SIZE;
  localparam int IDX_W = lpht_pkg::IDX_W;

  // Control and item registers.
  lpht_pkg::state_t          state_r, state_nxt;
  logic                      action_r, action_nxt;
  logic [lpht_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [lpht_pkg::REC_W-1:0] rec_r, rec_nxt;
  logic [IDX_W-1:0]          pos_r, pos_nxt;
  logic [IDX_W-1:0]          tries_r, tries_nxt;
  logic [TS-1:0]             occ_r, occ_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  lpht_pkg::status_t             out_status_r, out_status_nxt;
  logic [lpht_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [lpht_pkg::REC_W-1:0]    out_data_r, out_data_nxt;

  // Memory port signals.
  lpht_pkg::entry_t          mem [TS];
  lpht_pkg::entry_t          rdata_r;
  logic [IDX_W-1:0]          rd_addr;
  logic                      wr_en;
  lpht_pkg::entry_t          wr_data;

  logic                      in_accept;
  logic                      out_free;
  logic                      cur_occ;
  logic                      last_try;
  logic [IDX_W-1:0]          home;
  logic [IDX_W-1:0]          pos_step;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cur_occ   = occ_r[pos_r];
  assign last_try  = (tries_r == IDX_W'(TS - 1));
  assign home      = IDX_W'(in_key % lpht_pkg::TABLE_SIZE);
  assign pos_step  = (pos_r == IDX_W'(TS - 1)) ? '0 : pos_r + 1'b1;
  assign wr_data   = '{key: key_r, rec: rec_r};

  // Next state, probe step and result formation.
  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    key_nxt        = key_r;
    rec_nxt        = rec_r;
    pos_nxt        = pos_r;
    tries_nxt      = tries_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    in_stall       = (state_r != lpht_pkg::S_IDLE);
    rd_addr        = pos_r;
    case (state_r)
      lpht_pkg::S_IDLE: begin
        rd_addr = home;
        if (in_accept) begin
          action_nxt = in_action;
          key_nxt    = in_key;
          rec_nxt    = in_record_data;
          pos_nxt    = home;
          tries_nxt  = '0;
          state_nxt  = lpht_pkg::S_PROBE;
        end
      end
      lpht_pkg::S_PROBE: begin
        if (action_r == lpht_pkg::ACT_INSERT) begin
          // Insert: the first free slot takes the entry.
          if (!cur_occ) begin
            if (out_free) begin
              wr_en          = 1'b1;
              occ_nxt[pos_r] = 1'b1;
              out_valid_nxt  = 1'b1;
              out_status_nxt = lpht_pkg::ST_INSERTED;
              out_slot_nxt   = lpht_pkg::SLOT_W'(pos_r);
              out_data_nxt   = '0;
              state_nxt      = lpht_pkg::S_IDLE;
            end
          end else if (last_try) begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = lpht_pkg::ST_FULL;
              out_slot_nxt   = '0;
              out_data_nxt   = '0;
              state_nxt      = lpht_pkg::S_IDLE;
            end
          end else begin
            pos_nxt   = pos_step;
            tries_nxt = tries_r + 1'b1;
            rd_addr   = pos_step;
          end
        end else begin
          // Search: stop on a match, a free slot, or after every slot.
          if (cur_occ && (rdata_r.key == key_r)) begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = lpht_pkg::ST_FOUND;
              out_slot_nxt   = lpht_pkg::SLOT_W'(pos_r);
              out_data_nxt   = rdata_r.rec;
              state_nxt      = lpht_pkg::S_IDLE;
            end
          end else if (!cur_occ || last_try) begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = lpht_pkg::ST_NOT_FOUND;
              out_slot_nxt   = '0;
              out_data_nxt   = '0;
              state_nxt      = lpht_pkg::S_IDLE;
            end
          end else begin
            pos_nxt   = pos_step;
            tries_nxt = tries_r + 1'b1;
            rd_addr   = pos_step;
          end
        end
      end
      default: begin
        state_nxt = lpht_pkg::S_IDLE;
      end
    endcase
  end

  // Control state with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    rec_r        <= rec_nxt;
    pos_r        <= pos_nxt;
    tries_r      <= tries_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Key and record memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_found_data = out_data_r;

  // An accepted item always starts a probe.
  a_accept_probe: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == lpht_pkg::S_PROBE))
    else $error("accepted item did not start a probe");

  // A completed insert leaves its slot marked occupied.
  a_insert_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> occ_r[$past(pos_r)])
    else $error("inserted slot not marked occupied");

  // A found result points at an occupied slot.
  a_found_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == lpht_pkg::ST_FOUND)) |-> occ_r[IDX_W'(out_slot_r)])
    else $error("found result names a free slot");

  // Full and not-found results carry zero slot and data.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_status_r == lpht_pkg::ST_FULL) ||
                     (out_status_r == lpht_pkg::ST_NOT_FOUND)))
      |-> ((out_slot_r == '0) && (out_data_r == '0)))
    else $error("miss result carries nonzero fields");

endmodule
